FILE: hw/rtl/irpcs_pkg.sv
// shared types, codes and reset values for the ir pulse code channel switch
`timescale 1ns / 1ps

package irpcs_pkg;

    // field widths
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned TICKS_W = 8;
    localparam int unsigned CHAN_W  = 3;
    localparam int unsigned ACT_W   = 2;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_EDGE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BUTTON  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TIMEOUT = 2'd2;

    // result actions
    localparam logic [ACT_W-1:0] ACT_NONE    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ADVANCE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_POWER   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_GAP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_BIT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_BIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NEXT_CODE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_CODE = 3'd4;

    // configuration reset values
    localparam logic [TICKS_W-1:0] RST_LONG_GAP   = 8'd80;
    localparam logic [TICKS_W-1:0] RST_ONE_BIT    = 8'd36;
    localparam logic [TICKS_W-1:0] RST_ZERO_BIT   = 8'd5;
    localparam logic [WORD_W-1:0]  RST_NEXT_CODE  = 32'h0001_8000;
    localparam logic [WORD_W-1:0]  RST_POWER_CODE = 32'hE0E0_40BF;

    // channel select values
    localparam logic [CHAN_W-1:0] CHAN_OFF   = 3'd0;
    localparam logic [CHAN_W-1:0] CHAN_FIRST = 3'd4;
    localparam logic [CHAN_W-1:0] CHAN_LAST  = 3'd7;

    typedef struct packed {
        logic [TICKS_W-1:0] long_gap;
        logic [TICKS_W-1:0] one_bit;
        logic [TICKS_W-1:0] zero_bit;
        logic [WORD_W-1:0]  next_code;
        logic [WORD_W-1:0]  power_code;
    } t_cfg;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [CHAN_W-1:0] chan;
    } t_state;

endpackage

FILE: hw/rtl/irpcs_step.sv
// next-state and action logic for one item of the channel switch
`timescale 1ns / 1ps

module irpcs_step
    import irpcs_pkg::*;
(
    input  t_cfg               i_cfg,
    input  t_state             i_state,
    input  logic [KIND_W-1:0]  i_kind,
    input  logic [TICKS_W-1:0] i_ticks,
    output t_state             o_next,
    output logic [ACT_W-1:0]   o_action
);

    logic [CHAN_W-1:0] w_chan_adv;
    logic [CHAN_W-1:0] w_chan_pwr;

    // advance: off or low codes jump to the first channel, last wraps to off
    always_comb begin
        if (!i_state.chan[CHAN_W-1]) begin
            w_chan_adv = CHAN_FIRST;
        end else if (i_state.chan == CHAN_LAST) begin
            w_chan_adv = CHAN_OFF;
        end else begin
            w_chan_adv = i_state.chan + CHAN_W'(1);
        end
    end

    // power toggle between off and the first channel
    assign w_chan_pwr = (i_state.chan != CHAN_OFF) ? CHAN_OFF : CHAN_FIRST;

    // per-kind update
    always_comb begin
        o_next   = i_state;
        o_action = ACT_NONE;
        case (i_kind)
            KIND_EDGE: begin
                if (i_ticks > i_cfg.long_gap) begin
                    o_next.word = '0;
                end else if (i_ticks > i_cfg.one_bit) begin
                    o_next.word = {i_state.word[WORD_W-2:0], 1'b1};
                end else if (i_ticks > i_cfg.zero_bit) begin
                    o_next.word = {i_state.word[WORD_W-2:0], 1'b0};
                end
            end
            KIND_BUTTON: begin
                o_next.chan = w_chan_adv;
                o_action    = ACT_ADVANCE;
            end
            KIND_TIMEOUT: begin
                // next code wins when both codes are equal
                if (i_state.word == i_cfg.next_code) begin
                    o_next.chan = w_chan_adv;
                    o_action    = ACT_ADVANCE;
                end else if (i_state.word == i_cfg.power_code) begin
                    o_next.chan = w_chan_pwr;
                    o_action    = ACT_POWER;
                end
                o_next.word = '0;
            end
            default: begin
                // unused kind leaves state alone
            end
        endcase
    end

endmodule

FILE: hw/rtl/ir_pulse_code_channel_switch_top.sv
// top level of the ir pulse code channel switch
`timescale 1ns / 1ps

// Pulse-distance IR remote decoder driving a 3-bit channel select.
// Input channel: i_in_valid / o_in_stall carry one beat of i_kind and i_ticks
// (IR falling edge with gap ticks, button press, or gap timeout).
// Output channel: o_out_valid / i_out_stall carry one result beat per input
// beat: o_channel_select, o_action and o_received_word after that item.
// Path: an accepted beat goes into the input register, then into the result register,
// which drives the output. Throughput: one beat per cycle while the output is not
// stalled, set by the combinational compare/shift step between the two registers.
// A stalled result holds in the result register; the input register still
// takes one more beat, and o_in_stall rises only when both are full.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 long gap, 1 one bit, 2 zero bit, 3 next code, 4 power code); write
// only while no beat is in flight. Indexes 5 to 7 are ignored.
// Reset (synchronous, active low): both registers empty, shift word and
// channel cleared, configuration back to its default values.

module ir_pulse_code_channel_switch_top
    import irpcs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [KIND_W-1:0]     i_kind,
    input  logic [TICKS_W-1:0]    i_ticks,
    // output channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [CHAN_W-1:0]     o_channel_select,
    output logic [ACT_W-1:0]      o_action,
    output logic [WORD_W-1:0]     o_received_word
);

    t_cfg               r_cfg;
    t_state             r_state;
    t_state             n_state;
    logic               r_in_valid;
    logic [KIND_W-1:0]  r_in_kind;
    logic [TICKS_W-1:0] r_in_ticks;
    logic               r_out_valid;
    logic [CHAN_W-1:0]  r_out_chan;
    logic [ACT_W-1:0]   r_out_act;
    logic [WORD_W-1:0]  r_out_word;
    logic [ACT_W-1:0]   n_action;
    logic               w_out_free;
    logic               w_advance;
    logic               w_in_take;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_gap   <= RST_LONG_GAP;
            r_cfg.one_bit    <= RST_ONE_BIT;
            r_cfg.zero_bit   <= RST_ZERO_BIT;
            r_cfg.next_code  <= RST_NEXT_CODE;
            r_cfg.power_code <= RST_POWER_CODE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LONG_GAP:   r_cfg.long_gap   <= i_cfg_data[TICKS_W-1:0];
                CFG_ONE_BIT:    r_cfg.one_bit    <= i_cfg_data[TICKS_W-1:0];
                CFG_ZERO_BIT:   r_cfg.zero_bit   <= i_cfg_data[TICKS_W-1:0];
                CFG_NEXT_CODE:  r_cfg.next_code  <= i_cfg_data[WORD_W-1:0];
                CFG_POWER_CODE: r_cfg.power_code <= i_cfg_data[WORD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // handshake control
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_advance  = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;
    assign w_in_take  = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_kind  <= i_kind;
            r_in_ticks <= i_ticks;
        end
    end

    // decode step
    irpcs_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_kind   (r_in_kind),
        .i_ticks  (r_in_ticks),
        .o_next   (n_state),
        .o_action (n_action)
    );

    // shift word and channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_advance) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_chan <= n_state.chan;
            r_out_act  <= n_action;
            r_out_word <= n_state.word;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_channel_select = r_out_chan;
    assign o_action         = r_out_act;
    assign o_received_word  = r_out_word;

    // channel never rests on the unused low codes
    a_chan_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.chan == CHAN_OFF) || r_state.chan[CHAN_W-1])
        else $error("channel state on an unused code");

    // a power toggle lands on off or the first channel
    a_power_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_action == ACT_POWER)) |->
        ((o_channel_select == CHAN_OFF) || (o_channel_select == CHAN_FIRST)))
        else $error("power toggle gave a bad channel");

    // a timeout beat always reports a cleared word
    a_timeout_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && (r_in_kind == KIND_TIMEOUT)) |=>
        (o_out_valid && (o_received_word == '0) && (r_state.word == '0)))
        else $error("timeout did not clear the shift word");

    // an edge beat never reports an action
    a_edge_no_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && (r_in_kind == KIND_EDGE)) |=> (o_action == ACT_NONE))
        else $error("edge beat reported an action");

endmodule

FILE: sim/irpcs_switch_checker.sv
// checker for the ir pulse code channel switch: predicts each result beat and compares it
`timescale 1ns / 1ps

module irpcs_switch_checker
    import irpcs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [KIND_W-1:0]     i_kind,
    input  logic [TICKS_W-1:0]    i_ticks,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [CHAN_W-1:0]     i_channel_select,
    input  logic [ACT_W-1:0]      i_action,
    input  logic [WORD_W-1:0]     i_received_word,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked,
    output int                    o_advances,
    output int                    o_toggles
);

    typedef struct packed {
        logic [CHAN_W-1:0] chan;
        logic [ACT_W-1:0]  act;
        logic [WORD_W-1:0] word;
    } t_switch_beat;

    t_cfg         cfg;
    t_state       decoder;
    t_switch_beat expected_beats[$];
    int           fails;
    int           checked;
    int           advances;
    int           toggles;

    // 0..3 jump to the first channel, 7 wraps to off
    function automatic logic [CHAN_W-1:0] next_channel(input logic [CHAN_W-1:0] chan);
        if (chan < CHAN_FIRST) return CHAN_FIRST;
        if (chan == CHAN_LAST) return CHAN_OFF;
        return chan + CHAN_W'(1);
    endfunction

    // one decoder step: new channel, action and shift word for a single input beat
    function automatic t_switch_beat decode_step(input t_state s, input t_cfg c,
                                                 input logic [KIND_W-1:0] kind,
                                                 input logic [TICKS_W-1:0] ticks);
        t_switch_beat r;
        r.chan = s.chan;
        r.act  = ACT_NONE;
        r.word = s.word;
        case (kind)
            KIND_EDGE: begin
                // strict compares, long gap first
                if (ticks > c.long_gap)
                    r.word = '0;
                else if (ticks > c.one_bit)
                    r.word = {s.word[WORD_W-2:0], 1'b1};
                else if (ticks > c.zero_bit)
                    r.word = {s.word[WORD_W-2:0], 1'b0};
            end
            KIND_BUTTON: begin
                r.chan = next_channel(s.chan);
                r.act  = ACT_ADVANCE;
            end
            KIND_TIMEOUT: begin
                // next code wins when both codes are equal
                if (s.word == c.next_code) begin
                    r.chan = next_channel(s.chan);
                    r.act  = ACT_ADVANCE;
                end else if (s.word == c.power_code) begin
                    r.chan = (s.chan != CHAN_OFF) ? CHAN_OFF : CHAN_FIRST;
                    r.act  = ACT_POWER;
                end
                r.word = '0;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic flag_field(input string field, input logic [WORD_W-1:0] want,
                              input logic [WORD_W-1:0] got);
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        fails++;
    endtask

    // watch config writes and both channels
    always @(posedge i_clk) begin
        t_switch_beat want;
        if (!i_rst_n) begin
            cfg = '{RST_LONG_GAP, RST_ONE_BIT, RST_ZERO_BIT, RST_NEXT_CODE, RST_POWER_CODE};
            decoder = '0;
            expected_beats.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_LONG_GAP:   cfg.long_gap   = i_cfg_data[TICKS_W-1:0];
                    CFG_ONE_BIT:    cfg.one_bit    = i_cfg_data[TICKS_W-1:0];
                    CFG_ZERO_BIT:   cfg.zero_bit   = i_cfg_data[TICKS_W-1:0];
                    CFG_NEXT_CODE:  cfg.next_code  = i_cfg_data[WORD_W-1:0];
                    CFG_POWER_CODE: cfg.power_code = i_cfg_data[WORD_W-1:0];
                    default: ;
                endcase
            end
            // result beat against the oldest expectation
            if (i_out_valid && !i_out_stall) begin
                if (expected_beats.size() == 0) begin
                    $error("result beat with nothing expected: chan %0d action %0d word 0x%0h",
                           i_channel_select, i_action, i_received_word);
                    fails++;
                end else begin
                    want = expected_beats.pop_front();
                    checked++;
                    if (want.act == ACT_ADVANCE) advances++;
                    if (want.act == ACT_POWER) toggles++;
                    if (i_channel_select !== want.chan)
                        flag_field("channel_select", WORD_W'(want.chan),
                                   WORD_W'(i_channel_select));
                    if (i_action !== want.act)
                        flag_field("action", WORD_W'(want.act), WORD_W'(i_action));
                    if (i_received_word !== want.word)
                        flag_field("received_word", want.word, i_received_word);
                end
            end
            // input beat updates the predicted decoder state
            if (i_in_valid && !i_in_stall) begin
                want = decode_step(decoder, cfg, i_kind, i_ticks);
                expected_beats.push_back(want);
                decoder.word = want.word;
                decoder.chan = want.chan;
            end
        end
        o_pending    <= expected_beats.size();
        o_fail_count <= fails;
        o_checked    <= checked;
        o_advances   <= advances;
        o_toggles    <= toggles;
    end

endmodule

FILE: sim/tb_ir_pulse_code_channel_switch_top.sv
// testbench top for the ir pulse code channel switch: stimulus, stalls and verdict
`timescale 1ns / 1ps

module tb_ir_pulse_code_channel_switch_top;
    import irpcs_pkg::*;

    // kind and register indexes the package leaves unnamed
    localparam logic [KIND_W-1:0]    KIND_SPARE    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_TOP = 3'd7;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic [KIND_W-1:0]     i_kind = '0;
    logic [TICKS_W-1:0]    i_ticks = '0;
    logic                  i_out_stall = 1'b0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [CHAN_W-1:0]     o_channel_select;
    logic [ACT_W-1:0]      o_action;
    logic [WORD_W-1:0]     o_received_word;

    int   fail_count;
    int   pending;
    int   checked;
    int   advances;
    int   toggles;
    int   sent_beats = 0;
    logic calm = 1'b0;
    logic hold_req = 1'b0;
    t_cfg active;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    ir_pulse_code_channel_switch_top DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_kind           (i_kind),
        .i_ticks          (i_ticks),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_channel_select (o_channel_select),
        .o_action         (o_action),
        .o_received_word  (o_received_word)
    );

    irpcs_switch_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_kind           (i_kind),
        .i_ticks          (i_ticks),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_channel_select (o_channel_select),
        .i_action         (o_action),
        .i_received_word  (o_received_word),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_checked        (checked),
        .o_advances       (advances),
        .o_toggles        (toggles)
    );

    // one input beat, with an occasional gap in front of it
    task automatic send_beat(input logic [KIND_W-1:0] kind, input logic [TICKS_W-1:0] ticks);
        int gap;
        gap = (!calm && $urandom_range(0, 99) < 7) ? $urandom_range(1, 3) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_ticks    <= ticks;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent_beats++;
    endtask

    // gap length that shifts in the wanted bit, random when the thresholds rule it out
    function automatic logic [TICKS_W-1:0] bit_gap(input logic one);
        if (one && active.one_bit < active.long_gap)
            return TICKS_W'($urandom_range(active.long_gap, active.one_bit + 1));
        if (!one && active.zero_bit < active.one_bit)
            return TICKS_W'($urandom_range(active.one_bit, active.zero_bit + 1));
        return TICKS_W'($urandom_range(0, 255));
    endfunction

    // frame start, 0 to 3 spare bits, 32 data bits amid stray beats, then the timeout
    task automatic send_frame(input logic [WORD_W-1:0] word);
        int extra;
        int pick;
        if (active.long_gap != 8'hFF)
            send_beat(KIND_EDGE, TICKS_W'($urandom_range(255, active.long_gap + 1)));
        extra = $urandom_range(0, 3);
        for (int i = WORD_W - 1 + extra; i >= 0; i--) begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                send_beat(KIND_EDGE, TICKS_W'($urandom_range(active.zero_bit, 0)));
            else if (pick < 6)
                send_beat(KIND_BUTTON, TICKS_W'($urandom));
            if (i < WORD_W)
                send_beat(KIND_EDGE, bit_gap(word[i]));
            else
                send_beat(KIND_EDGE, bit_gap(1'($urandom_range(0, 1))));
        end
        send_beat(KIND_TIMEOUT, TICKS_W'($urandom));
    endtask

    // mostly well formed frames, the rest random beats of every kind
    task automatic run_random(input int goal);
        int stop;
        int n;
        logic [WORD_W-1:0] word;
        stop = sent_beats + goal;
        while (sent_beats < stop) begin
            if ($urandom_range(0, 99) < 65) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: word = active.next_code;
                    4, 5, 6:    word = active.power_code;
                    7:          word = active.next_code ^ (32'h1 << $urandom_range(0, 31));
                    default:    word = $urandom;
                endcase
                send_frame(word);
            end else begin
                n = $urandom_range(1, 6);
                repeat (n) send_beat(KIND_W'($urandom_range(0, 3)), TICKS_W'($urandom));
            end
        end
    endtask

    // stop sending and let every expected result come out
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    // narrow registers get random upper data bits, spare indexes get junk
    task automatic load_settings(input t_cfg c);
        write_reg(CFG_LONG_GAP, {24'($urandom), c.long_gap});
        write_reg(CFG_ONE_BIT, {24'($urandom), c.one_bit});
        write_reg(CFG_ZERO_BIT, {24'($urandom), c.zero_bit});
        write_reg(CFG_NEXT_CODE, c.next_code);
        write_reg(CFG_POWER_CODE, c.power_code);
        write_reg(CFG_SPARE, $urandom);
        write_reg(CFG_SPARE_TOP, $urandom);
        i_cfg_we <= 1'b0;
        active = c;
    endtask

    // receiver: random stalls plus one long hold-off
    initial begin
        logic hold_done;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                i_out_stall <= 1'b1;
                repeat (64) @(posedge i_clk);
            end
            i_out_stall <= !calm && ($urandom_range(0, 99) < 7);
        end
    end

    // main sequence
    initial begin
        t_cfg plan[5];
        plan[0] = '{8'hFF, 8'h80, 8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        plan[1] = '{8'h00, 8'h00, 8'h00, 32'h0, $urandom};
        plan[2] = '{8'd200, 8'd100, 8'd20, $urandom, $urandom};
        plan[3] = '{8'd100, 8'd60, 8'hFF, 32'hFFFF_FFFF, 32'h0};
        plan[4] = '{RST_LONG_GAP, RST_ONE_BIT, RST_ZERO_BIT, RST_NEXT_CODE, RST_POWER_CODE};
        active  = plan[4];

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: spare kind, channel wrap, gap thresholds at and around each edge
        send_beat(KIND_SPARE, 8'hFF);
        send_beat(KIND_SPARE, 8'h00);
        repeat (5) send_beat(KIND_BUTTON, 8'h00);
        send_beat(KIND_EDGE, 8'hFF);
        send_beat(KIND_EDGE, 8'h00);
        send_beat(KIND_EDGE, RST_ZERO_BIT);
        send_beat(KIND_EDGE, RST_ZERO_BIT + TICKS_W'(1));
        send_beat(KIND_EDGE, RST_ONE_BIT);
        send_beat(KIND_EDGE, RST_ONE_BIT + TICKS_W'(1));
        send_beat(KIND_EDGE, RST_LONG_GAP);
        send_beat(KIND_SPARE, 8'h5A);
        send_beat(KIND_EDGE, RST_LONG_GAP + TICKS_W'(1));
        send_beat(KIND_EDGE, RST_ONE_BIT + TICKS_W'(1));
        send_beat(KIND_EDGE, RST_ONE_BIT + TICKS_W'(1));
        send_beat(KIND_TIMEOUT, 8'h00);
        send_beat(KIND_TIMEOUT, 8'hFF);
        send_beat(KIND_BUTTON, 8'hFF);
        send_beat(KIND_EDGE, 8'hAA);
        send_beat(KIND_EDGE, 8'h55);

        // reset settings, with the long receiver hold-off early on
        hold_req <= 1'b1;
        run_random(80);

        foreach (plan[p]) begin
            drain();
            load_settings(plan[p]);
            calm = (p == 2);
            run_random(70);
        end
        calm = 1'b0;

        drain();
        repeat (6) @(posedge i_clk);
        $display("sent %0d input beats over six register settings, %0d results checked",
                 sent_beats, checked);
        $display("saw %0d channel advances and %0d power toggles, %0d errors",
                 advances, toggles, fail_count);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // run limit
    initial begin
        #400_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: ir_pulse_code_channel_switch_top.f
hw/rtl/irpcs_pkg.sv
hw/rtl/irpcs_step.sv
hw/rtl/ir_pulse_code_channel_switch_top.sv
sim/irpcs_switch_checker.sv
sim/tb_ir_pulse_code_channel_switch_top.sv
